[design/assert_macros.svh]
// assertion helpers used by the walker rtl
// clocked, reset-gated concurrent checks reporting through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while reset is asserted
`define VRLW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("walker assertion failed");

// overlapping implication check, disabled while reset is asserted
`define VRLW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("walker implication failed");

// next-cycle implication check, disabled while reset is asserted
`define VRLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("walker next-cycle check failed");

`endif

[design/vrlw_pkg.sv]
// shared types and codes of the voxel ray line walker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vrlw_pkg;

    // request codes of an input beat
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_ANSWER = 1'b1;

    // result kinds of an output beat
    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_MISS  = 2'd2
    } t_kind;

    // per-axis control from the walker sequencing
    typedef struct packed {
        logic load;
        logic step;
    } t_axis_ctrl;

endpackage

`default_nettype wire

[design/voxel_ray_line_walker_unit.sv]
// voxel ray line walker: 3d error-accumulator line stepper, one voxel per beat
// an input beat passes the input register, then the result register, on its way to a result beat
// throughput one input beat per cycle while the result side does not stall; an answer while idle gives no result beat
// synchronous active-low reset clears the walk state and the valid flags of the input and the result registers
// depends on vrlw_pkg, vrlw_axis and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module voxel_ray_line_walker_unit import vrlw_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_req_type,
    input  wire logic [COORD_WIDTH-1:0] i_from_x,
    input  wire logic [COORD_WIDTH-1:0] i_from_y,
    input  wire logic [COORD_WIDTH-1:0] i_from_z,
    input  wire logic [COORD_WIDTH-1:0] i_to_x,
    input  wire logic [COORD_WIDTH-1:0] i_to_y,
    input  wire logic [COORD_WIDTH-1:0] i_to_z,
    input  wire logic [7:0]             i_density,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic      [1:0]             o_kind,
    output logic      [COORD_WIDTH-1:0] o_pos_x,
    output logic      [COORD_WIDTH-1:0] o_pos_y,
    output logic      [COORD_WIDTH-1:0] o_pos_z
);

    localparam int DW = COORD_WIDTH + 1;

    // input register
    logic                   r_in_valid;
    logic                   r_in_type;
    logic [COORD_WIDTH-1:0] r_from [3];
    logic [COORD_WIDTH-1:0] r_to   [3];
    logic [7:0]             r_density;

    // walk state
    logic          r_busy;
    logic [DW-1:0] r_major;
    logic [DW-1:0] r_count;

    // result register
    logic                   r_out_valid;
    t_kind                  r_kind;
    logic [COORD_WIDTH-1:0] r_pos [3];

    logic                   w_fire;
    logic                   w_is_start;
    logic                   w_is_answer;
    logic                   w_hit;
    t_axis_ctrl             w_ctrl;
    logic [DW-1:0]          w_abs_load [3];
    logic [COORD_WIDTH-1:0] w_pos_step [3];
    logic [COORD_WIDTH-1:0] w_prev     [3];
    logic [DW-1:0]          w_major_xy;
    logic [DW-1:0]          n_major;
    logic [DW-1:0]          n_count;
    logic                   w_done;
    logic                   n_busy;
    logic                   w_emit;
    t_kind                  n_kind;
    logic [COORD_WIDTH-1:0] n_pos [3];

    // handshake: the held beat moves on when the result register is free
    always_comb begin
        w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
        o_in_stall  = r_in_valid && !w_fire;
        w_is_start  = r_in_type == REQ_START;
        w_is_answer = r_in_type == REQ_ANSWER;
        w_ctrl.load = w_fire && w_is_start;
        w_hit       = w_fire && w_is_answer && r_busy && (r_density != 8'd0);
        w_ctrl.step = w_fire && w_is_answer && r_busy && (r_density == 8'd0);
    end

    // per-axis steppers
    for (genvar g = 0; g < 3; g++) begin : g_axis
        vrlw_axis #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_axis (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_from     (r_from[g]),
            .i_to       (r_to[g]),
            .i_major    (r_major),
            .o_abs_load (w_abs_load[g]),
            .o_pos_step (w_pos_step[g]),
            .o_prev     (w_prev[g])
        );
    end

    // major length of a new ray and the step counter
    always_comb begin
        w_major_xy = (w_abs_load[0] > w_abs_load[1]) ? w_abs_load[0] : w_abs_load[1];
        n_major    = (w_abs_load[2] > w_major_xy) ? w_abs_load[2] : w_major_xy;
        n_count    = r_count + {{(DW-1){1'b0}}, 1'b1};
        w_done     = n_count >= r_major;
    end

    // result selection
    always_comb begin
        w_emit = w_ctrl.load || w_ctrl.step || w_hit;
        n_busy = r_busy;
        n_kind = KIND_MISS;
        for (int i = 0; i < 3; i++) begin
            n_pos[i] = '0;
        end
        if (w_ctrl.load) begin
            n_busy = n_major != '0;
            if (n_major != '0) begin
                n_kind = KIND_QUERY;
                for (int i = 0; i < 3; i++) begin
                    n_pos[i] = r_from[i];
                end
            end
        end else if (w_hit) begin
            n_busy = 1'b0;
            n_kind = KIND_HIT;
            for (int i = 0; i < 3; i++) begin
                n_pos[i] = w_prev[i];
            end
        end else if (w_ctrl.step) begin
            n_busy = !w_done;
            if (!w_done) begin
                n_kind = KIND_QUERY;
                for (int i = 0; i < 3; i++) begin
                    n_pos[i] = w_pos_step[i];
                end
            end
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_type <= i_req_type;
            r_from[0] <= i_from_x;
            r_from[1] <= i_from_y;
            r_from[2] <= i_from_z;
            r_to[0]   <= i_to_x;
            r_to[1]   <= i_to_y;
            r_to[2]   <= i_to_z;
            r_density <= i_density;
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy <= n_busy;
            if (w_ctrl.load) begin
                r_count <= '0;
            end else if (w_ctrl.step) begin
                r_count <= n_count;
            end
        end
    end

    // major length of the running ray
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_major <= n_major;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_kind <= n_kind;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= n_pos[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];

    // a running walk has voxels left to query
    `VRLW_ASSERT_IMP(a_busy_count, i_clk, i_rst_n, r_busy, r_count < r_major)
    // a ray load leaves the walker busy exactly when its length is nonzero
    `VRLW_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_ctrl.load, r_busy == (r_major != '0))
    // a stalled result beat is never dropped
    `VRLW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule

`default_nettype wire

[design/vrlw_axis.sv]
// one axis of the line walker: delta, step sign, error accumulator, position
// depends on vrlw_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrlw_axis import vrlw_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire t_axis_ctrl             i_ctrl,
    input  wire logic [COORD_WIDTH-1:0] i_from,
    input  wire logic [COORD_WIDTH-1:0] i_to,
    input  wire logic [COORD_WIDTH:0]   i_major,
    output logic      [COORD_WIDTH:0]   o_abs_load,
    output logic      [COORD_WIDTH-1:0] o_pos_step,
    output logic      [COORD_WIDTH-1:0] o_prev
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int EW = COORD_WIDTH + 2;

    logic [COORD_WIDTH-1:0] r_cur;
    logic [COORD_WIDTH-1:0] r_prev;
    logic [DW-1:0]          r_abs;
    logic [EW-1:0]          r_err;
    logic                   r_neg;

    logic [DW-1:0]          w_delta;
    logic                   w_delta_neg;
    logic [EW-1:0]          w_err_sum;
    logic                   w_adv;
    logic [COORD_WIDTH-1:0] w_cur_adv;

    // signed delta of the sign-extended endpoints and its magnitude
    always_comb begin
        w_delta     = {i_to[COORD_WIDTH-1], i_to} - {i_from[COORD_WIDTH-1], i_from};
        w_delta_neg = w_delta[DW-1];
        o_abs_load  = w_delta_neg ? (~w_delta + {{(DW-1){1'b0}}, 1'b1}) : w_delta;
    end

    // error accumulate and strict compare against the major length
    always_comb begin
        w_err_sum = r_err + {1'b0, r_abs};
        w_adv     = w_err_sum > {1'b0, i_major};
        w_cur_adv = r_neg ? (r_cur - {{(COORD_WIDTH-1){1'b0}}, 1'b1})
                          : (r_cur + {{(COORD_WIDTH-1){1'b0}}, 1'b1});
        o_pos_step = w_adv ? w_cur_adv : r_cur;
    end

    assign o_prev = r_prev;

    // axis state update on ray load or one voxel advance
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_abs  <= o_abs_load;
            r_err  <= {1'b0, o_abs_load};
            r_neg  <= w_delta_neg || (w_delta == '0);
            r_cur  <= i_from;
            r_prev <= i_from;
        end else if (i_ctrl.step) begin
            r_prev <= r_cur;
            r_cur  <= o_pos_step;
            r_err  <= w_adv ? (w_err_sum - {1'b0, i_major}) : w_err_sum;
        end
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for voxel_ray_line_walker_unit: directed table, then random ray walks
// scoreboard fed by a bit-true line stepper model; depends on vrlw_pkg and the unit rtl

module tb_top import vrlw_pkg::*;;

    localparam int CW = 32;
    localparam int N_ITEMS = 1500;
    localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
    localparam logic [CW-1:0] CMIN = 32'h8000_0000;
    localparam logic [CW-1:0] ONES = 32'hffff_ffff;

    // how a beat's result is judged
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_TYPED
    } t_chk;

    typedef struct packed {
        logic          req;
        logic [CW-1:0] fx;
        logic [CW-1:0] fy;
        logic [CW-1:0] fz;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        logic [CW-1:0] tz;
        logic [7:0]    dens;
        t_chk          chk;
        t_kind         ekind;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [CW-1:0] ez;
    } t_beat;

    typedef struct packed {
        t_kind         kind;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } t_res;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic          i_req_type = REQ_START;
    logic [CW-1:0] i_from_x = '0;
    logic [CW-1:0] i_from_y = '0;
    logic [CW-1:0] i_from_z = '0;
    logic [CW-1:0] i_to_x = '0;
    logic [CW-1:0] i_to_y = '0;
    logic [CW-1:0] i_to_z = '0;
    logic [7:0]    i_density = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [1:0]    o_kind;
    logic [CW-1:0] o_pos_x;
    logic [CW-1:0] o_pos_y;
    logic [CW-1:0] o_pos_z;

    // walker model state
    logic [CW-1:0] wk_cur [3];
    logic [CW-1:0] wk_prev [3];
    logic [63:0]   wk_delta [3];
    logic [63:0]   wk_err [3];
    bit            wk_neg [3];
    logic [63:0]   wk_len;
    logic [63:0]   wk_cnt;
    bit            wk_busy;

    t_res  pending_voxels [$];
    t_beat cur_beat = '0;
    int    mismatches = 0;
    int    walked = 0;
    bit    quiet = 1'b0;
    bit    calm = 1'b0;
    int    stall_left = 0;

    // directed table: extremes, every request, the listed corner cases
    localparam int N_DIR = 23;
    t_beat dir_tab [N_DIR] = '{
        // answer straight after reset, idle so nothing comes back
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_NONE, KIND_QUERY, 0, 0, 0},
        // equal endpoints give a miss at once
        '{REQ_START, 1, 2, 3, 1, 2, 3, 8'h00, CHK_TYPED, KIND_MISS, 0, 0, 0},
        // short walk along x, y drifting, z flat
        '{REQ_START, 0, 0, 0, 3, 1, 0, 8'h00, CHK_TYPED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        // answer after the walk has ended is ignored
        '{REQ_ANSWER, ONES, ONES, ONES, ONES, ONES, ONES, 8'hff, CHK_NONE, KIND_QUERY,
          0, 0, 0},
        // solid first voxel reports the start voxel
        '{REQ_START, 5, 5, 5, 2, 5, 9, 8'h00, CHK_TYPED, KIND_QUERY, 5, 5, 5},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'hff, CHK_TYPED, KIND_HIT, 5, 5, 5},
        // full coordinate span
        '{REQ_START, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, 8'h00, CHK_TYPED, KIND_QUERY,
          CMIN, CMIN, CMAX},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h01, CHK_PRED, KIND_QUERY, 0, 0, 0},
        // walk hugging the top and bottom of the range
        '{REQ_START, CMAX, CMIN, 0, CMAX - 3, CMIN + 2, 0, 8'h00, CHK_TYPED, KIND_QUERY,
          CMAX, CMIN, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        // start while busy drops the running walk
        '{REQ_START, 10, -10, 7, 14, -13, 7, 8'h00, CHK_TYPED, KIND_QUERY, 10, -10, 7},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0},
        '{REQ_ANSWER, 0, 0, 0, 0, 0, 0, 8'h80, CHK_PRED, KIND_QUERY, 0, 0, 0},
        // all-ones endpoints
        '{REQ_START, ONES, ONES, ONES, ONES, ONES, ONES, 8'hff, CHK_TYPED, KIND_MISS,
          0, 0, 0},
        // alternating bit patterns, one-voxel walk
        '{REQ_START, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5556,
          32'haaaa_aaaa, 32'h5555_5555, 8'haa, CHK_TYPED, KIND_QUERY,
          32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
        '{REQ_ANSWER, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
          32'h5555_5555, 32'haaaa_aaaa, 8'h00, CHK_PRED, KIND_QUERY, 0, 0, 0}
    };

    voxel_ray_line_walker_unit #(
        .COORD_WIDTH(CW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_from_x   (i_from_x),
        .i_from_y   (i_from_y),
        .i_from_z   (i_from_z),
        .i_to_x     (i_to_x),
        .i_to_y     (i_to_y),
        .i_to_z     (i_to_z),
        .i_density  (i_density),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind     (o_kind),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pos_z    (o_pos_z)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // advance the line stepper by one beat; returns 1 when a result beat follows
    function automatic bit walker_next(input t_beat b, output t_res r);
        logic [CW-1:0] fr [3];
        logic [CW-1:0] dst [3];
        logic [63:0]   f;
        logic [63:0]   t;
        logic [63:0]   d;
        bit            neg;
        r   = '{KIND_MISS, '0, '0, '0};
        fr  = '{b.fx, b.fy, b.fz};
        dst = '{b.tx, b.ty, b.tz};
        if (b.req == REQ_START) begin
            for (int a = 0; a < 3; a++) begin
                f = {{(64 - CW){fr[a][CW-1]}}, fr[a]};
                t = {{(64 - CW){dst[a][CW-1]}}, dst[a]};
                d = t - f;
                neg = d[63];
                // a flat axis counts as stepping down but never moves
                wk_neg[a]   = neg || (d == 0);
                wk_delta[a] = neg ? -d : d;
                wk_err[a]   = wk_delta[a];
                wk_cur[a]   = fr[a];
                wk_prev[a]  = fr[a];
            end
            wk_len = (wk_delta[0] > wk_delta[1]) ? wk_delta[0] : wk_delta[1];
            if (wk_delta[2] > wk_len)
                wk_len = wk_delta[2];
            wk_cnt = '0;
            if (wk_len == 0) begin
                wk_busy = 1'b0;
                return 1'b1;
            end
            wk_busy = 1'b1;
            r = '{KIND_QUERY, wk_cur[0], wk_cur[1], wk_cur[2]};
            return 1'b1;
        end
        if (!wk_busy)
            return 1'b0;
        // solid voxel: report the last free one
        if (b.dens != 8'h00) begin
            wk_busy = 1'b0;
            r = '{KIND_HIT, wk_prev[0], wk_prev[1], wk_prev[2]};
            return 1'b1;
        end
        // strict compare against the major length
        for (int a = 0; a < 3; a++) begin
            wk_prev[a] = wk_cur[a];
            wk_err[a]  = wk_err[a] + wk_delta[a];
            if (wk_err[a] > wk_len) begin
                wk_err[a] = wk_err[a] - wk_len;
                wk_cur[a] = wk_neg[a] ? wk_cur[a] - 1'b1 : wk_cur[a] + 1'b1;
            end
        end
        wk_cnt = wk_cnt + 1;
        if (wk_cnt >= wk_len) begin
            wk_busy = 1'b0;
            return 1'b1;
        end
        r = '{KIND_QUERY, wk_cur[0], wk_cur[1], wk_cur[2]};
        return 1'b1;
    endfunction

    // scoreboard: queue the expected voxel on each input beat, check each result beat
    always @(posedge i_clk) begin : scoreboard
        t_res want;
        bit   has;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                has = walker_next(cur_beat, want);
                case (cur_beat.chk)
                    CHK_TYPED: begin
                        has  = 1'b1;
                        want = '{cur_beat.ekind, cur_beat.ex, cur_beat.ey, cur_beat.ez};
                    end
                    CHK_NONE: has = 1'b0;
                    default: ;
                endcase
                if (has)
                    pending_voxels.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_voxels.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d", o_kind);
                    mismatches++;
                end else begin
                    want = pending_voxels.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        mismatches++;
                    end
                    if (o_pos_x !== want.x) begin
                        $error("pos_x: expected %h, got %h", want.x, o_pos_x);
                        mismatches++;
                    end
                    if (o_pos_y !== want.y) begin
                        $error("pos_y: expected %h, got %h", want.y, o_pos_y);
                        mismatches++;
                    end
                    if (o_pos_z !== want.z) begin
                        $error("pos_z: expected %h, got %h", want.z, o_pos_z);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // present one beat, hold it until taken, then maybe leave a gap
    task automatic send_beat(input t_beat b);
        cur_beat   <= b;
        i_in_valid <= 1'b1;
        i_req_type <= b.req;
        i_from_x   <= b.fx;
        i_from_y   <= b.fy;
        i_from_z   <= b.fz;
        i_to_x     <= b.tx;
        i_to_y     <= b.ty;
        i_to_z     <= b.tz;
        i_density  <= b.dens;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (!(quiet || calm) && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // one ray: a start, a run of answers with maybe a solid voxel, now and then stray answers
    task automatic random_walk();
        t_beat          b;
        longint         dl [3];
        longint unsigned len;
        longint unsigned mag;
        int             n_ans;
        int             hit_at;
        int             span;
        int             mode;
        mode   = $urandom_range(0, 19);
        calm   = ($urandom_range(0, 5) == 0);
        span   = ($urandom_range(0, 4) == 0) ? 40 : 6;
        b      = '0;
        b.req  = REQ_START;
        b.chk  = CHK_PRED;
        b.dens = 8'($urandom);
        b.fx   = $urandom;
        b.fy   = $urandom;
        b.fz   = $urandom;
        if (mode == 0) begin
            // unrelated endpoints, a very long walk cut short
            b.tx = $urandom;
            b.ty = $urandom;
            b.tz = $urandom;
        end else if (mode == 1) begin
            b.tx = b.fx;
            b.ty = b.fy;
            b.tz = b.fz;
        end else begin
            if (mode < 8) begin
                b.fx = $urandom_range(0, 64) - 32;
                b.fy = $urandom_range(0, 64) - 32;
                b.fz = $urandom_range(0, 64) - 32;
            end else if (mode < 10) begin
                // close to the ends of the coordinate range
                b.fx = $urandom_range(0, 1) ? CMAX - $urandom_range(0, 8)
                                            : CMIN + $urandom_range(0, 8);
                b.fy = $urandom_range(0, 1) ? CMAX - $urandom_range(0, 8)
                                            : CMIN + $urandom_range(0, 8);
                b.fz = $urandom_range(0, 1) ? CMAX - $urandom_range(0, 8)
                                            : CMIN + $urandom_range(0, 8);
            end
            b.tx = b.fx + $urandom_range(0, 2 * span) - span;
            b.ty = b.fy + $urandom_range(0, 2 * span) - span;
            b.tz = b.fz + $urandom_range(0, 2 * span) - span;
        end
        dl[0] = longint'($signed(b.tx)) - longint'($signed(b.fx));
        dl[1] = longint'($signed(b.ty)) - longint'($signed(b.fy));
        dl[2] = longint'($signed(b.tz)) - longint'($signed(b.fz));
        len = 0;
        for (int a = 0; a < 3; a++) begin
            mag = (dl[a] < 0) ? -dl[a] : dl[a];
            if (mag > len)
                len = mag;
        end
        if (len > 200) begin
            n_ans = $urandom_range(0, 12);
        end else begin
            n_ans = int'(len);
            if ($urandom_range(0, 7) == 0)
                n_ans = $urandom_range(0, n_ans);
        end
        hit_at = -1;
        if (n_ans > 0 && $urandom_range(0, 2) == 0)
            hit_at = $urandom_range(0, n_ans - 1);
        send_beat(b);
        walked++;
        for (int k = 0; k < n_ans; k++) begin
            b.req  = REQ_ANSWER;
            b.fx   = $urandom;
            b.fy   = $urandom;
            b.fz   = $urandom;
            b.tx   = $urandom;
            b.ty   = $urandom;
            b.tz   = $urandom;
            b.dens = (k == hit_at) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_beat(b);
            walked++;
            if (k == hit_at)
                break;
        end
        // stray answers, mostly landing on an idle walker
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                b.req  = REQ_ANSWER;
                b.dens = 8'($urandom);
                send_beat(b);
            end
        end
    endtask

    // stimulus and end of run
    initial begin : stimulus
        bit drained;
        drained = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIR; k++)
            send_beat(dir_tab[k]);
        while (walked < N_ITEMS) begin
            // sender holds off once until every result is back
            if (!drained && walked >= N_ITEMS / 2) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_voxels.size() != 0)
                    @(posedge i_clk);
                repeat (4) @(posedge i_clk);
            end
            quiet = (walked >= N_ITEMS - 150);
            random_walk();
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_voxels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
